// File: rtl/core/pwfc_pkg.sv
package pwfc_pkg;

    // Register file layout, one 32-bit word per register.
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_KF      = 3'd3,
        REG_I_LIMIT = 3'd4,
        REG_O_LIMIT = 3'd5
    } t_reg_idx;

    // Request function codes carried on the func field.
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam logic [14:0] O_LIMIT_RESET = 15'h7FFF;

    // Operand and product widths, sized for the worst case of each term.
    localparam int unsigned ERR_W  = 17;
    localparam int unsigned INT_W  = 21;
    localparam int unsigned DERR_W = 18;
    localparam int unsigned DTGT_W = 17;
    localparam int unsigned PP_W   = 33;
    localparam int unsigned PI_W   = 37;
    localparam int unsigned PD_W   = 34;
    localparam int unsigned PF_W   = 33;
    localparam int unsigned SUM_W  = 39;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic signed [15:0] kf;
        logic [19:0]        i_limit;
        logic [14:0]        o_limit;
    } t_cfg;

    typedef struct packed {
        logic               func;
        logic signed [15:0] measured;
        logic signed [15:0] target;
    } t_item;

    typedef struct packed {
        logic                     clr;
        logic signed [ERR_W-1:0]  err;
        logic signed [INT_W-1:0]  integ;
        logic signed [DERR_W-1:0] derr;
        logic signed [DTGT_W-1:0] dtgt;
    } t_ops;

    typedef struct packed {
        logic                   clr;
        logic signed [PP_W-1:0] p;
        logic signed [PI_W-1:0] i;
        logic signed [PD_W-1:0] d;
        logic signed [PF_W-1:0] f;
    } t_prod;

endpackage

// File: rtl/core/pwfc_regs.sv
module pwfc_regs
    import pwfc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output t_cfg                o_cfg
);

    t_cfg            r_cfg;
    t_cfg            n_cfg;
    logic [IDX_W-1:0] idx;
    logic            wr_en;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_KP:      n_cfg.kp      = pwdata[15:0];
                REG_KI:      n_cfg.ki      = pwdata[15:0];
                REG_KD:      n_cfg.kd      = pwdata[15:0];
                REG_KF:      n_cfg.kf      = pwdata[15:0];
                REG_I_LIMIT: n_cfg.i_limit = pwdata[19:0];
                REG_O_LIMIT: n_cfg.o_limit = pwdata[14:0];
                default:     n_cfg         = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp      <= '0;
            r_cfg.ki      <= '0;
            r_cfg.kd      <= '0;
            r_cfg.kf      <= '0;
            r_cfg.i_limit <= '0;
            r_cfg.o_limit <= O_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (idx)
            REG_KP:      prdata = {16'd0, r_cfg.kp};
            REG_KI:      prdata = {16'd0, r_cfg.ki};
            REG_KD:      prdata = {16'd0, r_cfg.kd};
            REG_KF:      prdata = {16'd0, r_cfg.kf};
            REG_I_LIMIT: prdata = {12'd0, r_cfg.i_limit};
            REG_O_LIMIT: prdata = {17'd0, r_cfg.o_limit};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pwfc_state.sv
module pwfc_state
    import pwfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_item       i_item,
    input  logic [19:0] i_i_limit,
    output t_ops        o_ops
);

    logic signed [INT_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [15:0]       r_prev_tgt;
    t_ops                     r_ops;
    t_ops                     n_ops;

    logic signed [ERR_W-1:0]  err;
    logic signed [INT_W:0]    isum;
    logic signed [INT_W:0]    lim_pos;
    logic signed [INT_W:0]    lim_neg;
    logic signed [INT_W:0]    iclamp;

    always_comb begin
        err     = $signed({i_item.target[15], i_item.target})
                - $signed({i_item.measured[15], i_item.measured});
        isum    = $signed({r_integ[INT_W-1], r_integ})
                + $signed({{(INT_W+1-ERR_W){err[ERR_W-1]}}, err});
        lim_pos = $signed({2'b00, i_i_limit});
        lim_neg = -lim_pos;

        // Symmetric saturation of the running error sum.
        if (isum > lim_pos) begin
            iclamp = lim_pos;
        end else if (isum < lim_neg) begin
            iclamp = lim_neg;
        end else begin
            iclamp = isum;
        end

        n_ops.clr   = (i_item.func == FUNC_CLEAR);
        n_ops.err   = err;
        n_ops.integ = iclamp[INT_W-1:0];
        n_ops.derr  = $signed({err[ERR_W-1], err})
                    - $signed({r_prev_err[ERR_W-1], r_prev_err});
        n_ops.dtgt  = $signed({i_item.target[15], i_item.target})
                    - $signed({r_prev_tgt[15], r_prev_tgt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
            r_prev_tgt <= '0;
        end else if (i_load) begin
            if (i_item.func == FUNC_CLEAR) begin
                // A clear keeps the last target.
                r_integ    <= '0;
                r_prev_err <= '0;
            end else begin
                r_integ    <= n_ops.integ;
                r_prev_err <= err;
                r_prev_tgt <= i_item.target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ops <= n_ops;
        end
    end

    assign o_ops = r_ops;

endmodule

// File: rtl/core/pwfc_mult.sv
module pwfc_mult
    import pwfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_ops  i_ops,
    input  t_cfg  i_cfg,
    output t_prod o_prod
);

    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod.clr = i_ops.clr;
        n_prod.p   = i_cfg.kp * i_ops.err;
        n_prod.i   = i_cfg.ki * i_ops.integ;
        n_prod.d   = i_cfg.kd * i_ops.derr;
        n_prod.f   = i_cfg.kf * i_ops.dtgt;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/pwfc_out.sv
module pwfc_out
    import pwfc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  t_prod              i_prod,
    input  logic [14:0]        i_o_limit,
    output logic signed [15:0] o_drive
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;
    logic signed [SUM_W-1:0] clamped;
    logic signed [15:0]      r_drive;
    logic signed [15:0]      n_drive;

    always_comb begin
        sum = $signed({{(SUM_W-PP_W){i_prod.p[PP_W-1]}}, i_prod.p})
            + $signed({{(SUM_W-PI_W){i_prod.i[PI_W-1]}}, i_prod.i})
            + $signed({{(SUM_W-PD_W){i_prod.d[PD_W-1]}}, i_prod.d})
            + $signed({{(SUM_W-PF_W){i_prod.f[PF_W-1]}}, i_prod.f});
        // Arithmetic shift drops the fraction and rounds toward minus infinity.
        shifted = sum >>> FRAC_BITS;
        lim_pos = $signed({{(SUM_W-15){1'b0}}, i_o_limit});
        lim_neg = -lim_pos;

        if (shifted > lim_pos) begin
            clamped = lim_pos;
        end else if (shifted < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = shifted;
        end

        n_drive = i_prod.clr ? 16'sd0 : clamped[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

// File: rtl/core/pid_with_feedforward_clamped_unit.sv
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-----------------------------
// input     | in        | i_in_valid / o_in_ready   | i_func, i_measured, i_target
// result    | out       | o_out_valid / i_out_ready | o_drive
// config    | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// The block takes one request per cycle while the result side keeps up. From
// acceptance, a request's drive passes through four register stages (input
// register, state update, multiply, sum and clamp) to the result channel.
// Reset is synchronous and active low, and there is no clearing pass. When
// the result side stalls, the pipeline fills behind the held result and
// o_in_ready drops only once every stage holds a request.
module pid_with_feedforward_clamped_unit
    import pwfc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic signed [15:0]  i_measured,
    input  logic signed [15:0]  i_target,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_drive,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    t_cfg  cfg;
    t_item r_item;
    t_ops  ops;
    t_prod prod;

    // One valid bit per stage; the input stage's payload is r_item here, later stages' live in their modules.
    logic r_s0_valid, n_s0_valid;
    logic r_s1_valid, n_s1_valid;
    logic r_s2_valid, n_s2_valid;
    logic r_out_valid, n_out_valid;

    logic in_acc;
    logic s0_mv, s1_mv, s2_mv;
    logic s1_acc, s2_acc, s3_acc;

    assign pready = 1'b1;

    // A stage can take a new request when it is empty or its request moves on.
    assign s3_acc     = !r_out_valid || i_out_ready;
    assign s2_mv      = r_s2_valid && s3_acc;
    assign s2_acc     = !r_s2_valid || s2_mv;
    assign s1_mv      = r_s1_valid && s2_acc;
    assign s1_acc     = !r_s1_valid || s1_mv;
    assign s0_mv      = r_s0_valid && s1_acc;
    assign o_in_ready = !r_s0_valid || s0_mv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_s0_valid  = in_acc ? 1'b1 : (s0_mv ? 1'b0 : r_s0_valid);
        n_s1_valid  = s0_mv ? 1'b1 : (s1_mv ? 1'b0 : r_s1_valid);
        n_s2_valid  = s1_mv ? 1'b1 : (s2_mv ? 1'b0 : r_s2_valid);
        n_out_valid = s2_mv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_valid  <= n_s0_valid;
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.func     <= i_func;
            r_item.measured <= i_measured;
            r_item.target   <= i_target;
        end
    end

    pwfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // The controller state advances exactly once per request, as it leaves
    // the input register.
    pwfc_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s0_mv),
        .i_item    (r_item),
        .i_i_limit (cfg.i_limit),
        .o_ops     (ops)
    );

    pwfc_mult u_mult (
        .i_clk  (i_clk),
        .i_load (s1_mv),
        .i_ops  (ops),
        .i_cfg  (cfg),
        .o_prod (prod)
    );

    pwfc_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk     (i_clk),
        .i_load    (s2_mv),
        .i_prod    (prod),
        .i_o_limit (cfg.o_limit),
        .o_drive   (o_drive)
    );

    assign o_out_valid = r_out_valid;

endmodule
